/* sv/msng_pkg.sv */
// Shared constants and types for the next-greater-element stack unit.
package msng_pkg;

  localparam int unsigned STACK_DEPTH_DEF   = 32;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned VALUE_W           = 32;

  localparam logic [VALUE_W-1:0] NONE_VALUE = '1;

  typedef struct packed {
    logic found;
    logic overflow;
    logic done;
  } res_flags_t;

endpackage

/* sv/msng_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module msng_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/msng_ctrl.sv */
// Stack sequencer: compare, pop, push and flush over the stack RAM.
module msng_ctrl #(
  parameter int unsigned STACK_DEPTH   = msng_pkg::STACK_DEPTH_DEF,
  parameter int unsigned POSITION_BITS = msng_pkg::POSITION_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [msng_pkg::VALUE_W-1:0]                  in_value_i,
  input  logic                                          in_final_i,
  output logic                                          res_valid_o,
  input  logic                                          res_ready_i,
  output logic [msng_pkg::VALUE_W-1:0]                  res_element_o,
  output logic [POSITION_BITS-1:0]                      res_position_o,
  output logic [msng_pkg::VALUE_W-1:0]                  res_next_o,
  output msng_pkg::res_flags_t                          res_flags_o,
  output logic                                          ram_we_o,
  output logic [$clog2(STACK_DEPTH)-1:0]                ram_waddr_o,
  output logic [msng_pkg::VALUE_W+POSITION_BITS-1:0]    ram_wdata_o,
  output logic                                          ram_re_o,
  output logic [$clog2(STACK_DEPTH)-1:0]                ram_raddr_o,
  input  logic [msng_pkg::VALUE_W+POSITION_BITS-1:0]    ram_rdata_i,
  output logic [$clog2(STACK_DEPTH+1)-1:0]              count_o
);
  import msng_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PUSH,
    S_FRD,
    S_FEM
  } state_e;

  state_e                   state_q;
  logic [CW-1:0]            cnt_q;
  logic [POSITION_BITS-1:0] pctr_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [VALUE_W-1:0]       val_q;
  logic                     fin_q;

  logic [VALUE_W-1:0]       rd_val;
  logic [POSITION_BITS-1:0] rd_pos;
  logic                     top_less;
  logic                     has_room;
  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            cnt_m2;

  assign rd_val   = ram_rdata_i[VALUE_W-1:0];
  assign rd_pos   = ram_rdata_i[VALUE_W+POSITION_BITS-1:VALUE_W];
  assign top_less = $signed(rd_val) < $signed(val_q);
  assign has_room = cnt_q < CW'(STACK_DEPTH);
  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_m2   = cnt_q - CW'(2);

  assign in_ready_o  = (state_q == S_IDLE);
  assign ram_waddr_o = cnt_q[AW-1:0];
  assign ram_wdata_o = {pos_q, val_q};
  assign count_o     = cnt_q;

  always_comb begin
    res_valid_o    = 1'b0;
    res_element_o  = rd_val;
    res_position_o = rd_pos;
    res_next_o     = NONE_VALUE;
    res_flags_o    = '0;
    ram_we_o       = 1'b0;
    ram_re_o       = 1'b0;
    ram_raddr_o    = cnt_m1[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        ram_re_o = in_valid_i && (cnt_q != '0);
      end
      S_CMP: begin
        if (top_less) begin
          res_valid_o       = 1'b1;
          res_next_o        = val_q;
          res_flags_o.found = 1'b1;
          ram_re_o          = res_ready_i && (cnt_q > CW'(1));
          ram_raddr_o       = cnt_m2[AW-1:0];
        end
      end
      S_PUSH: begin
        if (has_room) begin
          ram_we_o = 1'b1;
        end else begin
          res_valid_o          = 1'b1;
          res_element_o        = val_q;
          res_position_o       = pos_q;
          res_flags_o.overflow = 1'b1;
        end
      end
      S_FRD: begin
        ram_re_o = 1'b1;
      end
      S_FEM: begin
        res_valid_o      = 1'b1;
        res_flags_o.done = (cnt_q == CW'(1));
        ram_re_o         = res_ready_i && (cnt_q > CW'(1));
        ram_raddr_o      = cnt_m2[AW-1:0];
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pctr_q  <= '0;
      pos_q   <= '0;
      val_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            val_q   <= in_value_i;
            fin_q   <= in_final_i;
            pos_q   <= pctr_q;
            pctr_q  <= in_final_i ? '0 : pctr_q + POSITION_BITS'(1);
            state_q <= (cnt_q != '0) ? S_CMP : S_PUSH;
          end
        end
        S_CMP: begin
          if (!top_less) begin
            state_q <= S_PUSH;
          end else if (res_ready_i) begin
            cnt_q   <= cnt_m1;
            state_q <= (cnt_q > CW'(1)) ? S_CMP : S_PUSH;
          end
        end
        S_PUSH: begin
          if (has_room) begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= fin_q ? S_FRD : S_IDLE;
          end else if (res_ready_i) begin
            state_q <= fin_q ? S_FRD : S_IDLE;
          end
        end
        S_FRD: begin
          state_q <= S_FEM;
        end
        S_FEM: begin
          if (res_ready_i) begin
            cnt_q   <= cnt_m1;
            state_q <= (cnt_q > CW'(1)) ? S_FEM : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/msng_out_reg.sv */
// Output register between the sequencer and the result stream.
module msng_out_reg #(
  parameter int unsigned POSITION_BITS = msng_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  output logic                         ready_o,
  input  logic [msng_pkg::VALUE_W-1:0] element_i,
  input  logic [POSITION_BITS-1:0]     position_i,
  input  logic [msng_pkg::VALUE_W-1:0] next_i,
  input  msng_pkg::res_flags_t         flags_i,
  output logic                         valid_o,
  input  logic                         taken_i,
  output logic [msng_pkg::VALUE_W-1:0] element_o,
  output logic [POSITION_BITS-1:0]     position_o,
  output logic [msng_pkg::VALUE_W-1:0] next_o,
  output msng_pkg::res_flags_t         flags_o
);
  import msng_pkg::*;

  logic                     valid_q;
  logic [VALUE_W-1:0]       element_q;
  logic [POSITION_BITS-1:0] position_q;
  logic [VALUE_W-1:0]       next_q;
  res_flags_t               flags_q;

  assign ready_o = !valid_q || taken_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (taken_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      element_q  <= element_i;
      position_q <= position_i;
      next_q     <= next_i;
      flags_q    <= flags_i;
    end
  end

  assign valid_o    = valid_q;
  assign element_o  = element_q;
  assign position_o = position_q;
  assign next_o     = next_q;
  assign flags_o    = flags_q;

endmodule

/* sv/monotonic_stack_next_greater_unit.sv */
// Top level of the next-greater-element unit built on a monotonic stack.
//
// Input stream: one signed 32-bit value per request in s_axis_tdata, with
// s_axis_tlast on the final value of a sequence. Output stream: one result
// per settled element (element, position, next greater value), flags in
// m_axis_tuser and m_axis_tlast on the last result of the final request.
// A request with value v pops every stacked entry smaller than v, each popped
// entry leaves as a result with v as its next greater value; v is then pushed.
// With the stack full, v leaves at once with the overflow flag. On the final
// request the remaining entries leave top first with next greater -1.
// Per request the stack top is read from RAM and compared; each pop reads the
// next entry, and a compare that does not pop leads to the push. A final
// request then reads and emits each remaining entry. RAM read data is
// registered. A stall on m_axis_tready holds the output register and freezes
// the sequencer; new requests wait until the current one is fully done.
// Reset empties the stack and zeroes the position counter; no RAM clearing
// is needed.
module monotonic_stack_next_greater_unit #(
  parameter int unsigned STACK_DEPTH   = msng_pkg::STACK_DEPTH_DEF,
  parameter int unsigned POSITION_BITS = msng_pkg::POSITION_BITS_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,
  // [31:0] value
  input  logic [31:0]                                       s_axis_tdata,
  input  logic                                              s_axis_tlast,
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,
  // element, position, next_greater, zero padding to whole bytes
  output logic [((2*msng_pkg::VALUE_W+POSITION_BITS+7)/8)*8-1:0] m_axis_tdata,
  // [0] found, [1] overflow
  output logic [1:0]                                        m_axis_tuser,
  output logic                                              m_axis_tlast
);
  import msng_pkg::*;

  localparam int unsigned AW      = $clog2(STACK_DEPTH);
  localparam int unsigned CW      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW      = VALUE_W + POSITION_BITS;
  localparam int unsigned TDATA_W = ((2 * VALUE_W + POSITION_BITS + 7) / 8) * 8;

  logic                     res_valid;
  logic                     res_ready;
  logic [VALUE_W-1:0]       res_element;
  logic [POSITION_BITS-1:0] res_position;
  logic [VALUE_W-1:0]       res_next;
  res_flags_t               res_flags;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [EW-1:0]            ram_rdata;
  logic [CW-1:0]            stack_count;

  logic [VALUE_W-1:0]       out_element;
  logic [POSITION_BITS-1:0] out_position;
  logic [VALUE_W-1:0]       out_next;
  res_flags_t               out_flags;

  msng_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  msng_ctrl #(
    .STACK_DEPTH   (STACK_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_value_i     (s_axis_tdata),
    .in_final_i     (s_axis_tlast),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_element_o  (res_element),
    .res_position_o (res_position),
    .res_next_o     (res_next),
    .res_flags_o    (res_flags),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .count_o        (stack_count)
  );

  msng_out_reg #(
    .POSITION_BITS (POSITION_BITS)
  ) u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .ready_o    (res_ready),
    .element_i  (res_element),
    .position_i (res_position),
    .next_i     (res_next),
    .flags_i    (res_flags),
    .valid_o    (m_axis_tvalid),
    .taken_i    (m_axis_tready),
    .element_o  (out_element),
    .position_o (out_position),
    .next_o     (out_next),
    .flags_o    (out_flags)
  );

  assign m_axis_tdata = TDATA_W'({out_next, out_position, out_element});
  assign m_axis_tuser = {out_flags.overflow, out_flags.found};
  assign m_axis_tlast = out_flags.done;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and overflow both set");

  a_none_on_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata[2*VALUE_W+POSITION_BITS-1:VALUE_W+POSITION_BITS] == NONE_VALUE))
    else $error("overflow result without none marker");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous one in work");

endmodule
